// ===== hdl/gcl_pkg.sv =====
`default_nettype none

package gcl_pkg;

    // Fixed-point configuration
    localparam int FRAC_DIGITS = 4;
    localparam int VALUE_WIDTH = 32;

    // Integer accumulators saturate at 2^ACC_W - 1
    localparam int ACC_W = (VALUE_WIDTH >= 32) ? 31 : VALUE_WIDTH - 1;
    localparam logic [ACC_W-1:0] VALUE_MAX = {ACC_W{1'b1}};

    localparam int RADIX = 10;

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * RADIX;
        end
        return p;
    endfunction

    localparam longint SCALE   = pow10(FRAC_DIGITS);
    localparam int     SCALE_W = $clog2(SCALE + 1);
    localparam int     FRAC_W  = $clog2(SCALE);
    localparam int     CNT_W   = $clog2(FRAC_DIGITS + 1);
    localparam int     MAG_W   = ACC_W + SCALE_W;

    localparam logic [15:0] CMD_MAX = 16'hFFFF;

    // Characters
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_Y      = 8'h59;
    localparam logic [7:0] CH_Z      = 8'h5A;

    typedef enum logic [2:0] {
        KIND_SPEED = 3'd0,
        KIND_FEED  = 3'd1,
        KIND_GCMD  = 3'd2,
        KIND_MCMD  = 3'd3,
        KIND_ERROR = 3'd4,
        KIND_END   = 3'd5
    } t_kind;

    // Weight of the next fraction digit, given how many were taken already
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [CNT_W-1:0] cnt);
        int e;
        e = FRAC_DIGITS - 1 - int'(cnt);
        if (e < 0) begin
            e = 0;
        end
        return FRAC_W'(pow10(e));
    endfunction

    typedef struct packed {
        logic [ACC_W-1:0]  int_accum;
        logic [FRAC_W-1:0] frac_scaled;
        logic              minus;
    } t_acc;

    typedef struct packed {
        logic [1:0]  cnt;
        t_kind       kind0;
        t_kind       kind1;
        logic [31:0] value0;
        logic [15:0] cmd;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } t_step;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] cmd;
        logic [31:0] value;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/gcl_fixed.sv =====
`default_nettype none

module gcl_fixed
    import gcl_pkg::*;
(
    input  t_acc               i_acc,
    output logic signed [31:0] o_real
);

    logic [MAG_W-1:0] mag;
    logic [ACC_W-1:0] mag_sat;

    always_comb begin
        mag = MAG_W'(i_acc.int_accum) * MAG_W'(SCALE) + MAG_W'(i_acc.frac_scaled);
        if (mag > MAG_W'(VALUE_MAX)) begin
            mag_sat = VALUE_MAX;
        end else begin
            mag_sat = mag[ACC_W-1:0];
        end
        if (i_acc.minus) begin
            o_real = -$signed(32'(mag_sat));
        end else begin
            o_real = $signed(32'(mag_sat));
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gcl_parse.sv =====
`default_nettype none

module gcl_parse
    import gcl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic signed [31:0] i_real,
    output t_acc               o_acc,
    output t_step              o_step
);

    typedef enum logic [4:0] {
        MODE_LINE = 5'b00001,
        MODE_CMD  = 5'b00010,
        MODE_WORD = 5'b00100,
        MODE_INT  = 5'b01000,
        MODE_FRAC = 5'b10000
    } t_mode;

    typedef enum logic [2:0] {
        TW_S = 3'd0,
        TW_F = 3'd1,
        TW_X = 3'd2,
        TW_Y = 3'd3,
        TW_Z = 3'd4
    } t_target;

    t_mode             r_mode,   n_mode;
    logic              r_is_m,   n_is_m;
    logic [15:0]       r_cmd,    n_cmd;
    logic [ACC_W-1:0]  r_int,    n_int;
    logic [FRAC_W-1:0] r_frac,   n_frac;
    logic [CNT_W-1:0]  r_fcnt,   n_fcnt;
    logic              r_minus,  n_minus;
    t_target           r_tgt,    n_tgt;
    logic [31:0]       r_x,      n_x;
    logic [31:0]       r_y,      n_y;
    logic [31:0]       r_z,      n_z;
    logic              r_halted, n_halted;

    logic              is_digit;
    logic [3:0]        digit;
    logic [ACC_W+3:0]  int_t;
    logic [19:0]       cmd_t;
    logic              do_line;
    logic              do_finish;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = is_digit ? 4'(i_byte - CH_ZERO) : 4'd0;
    assign int_t    = (ACC_W+4)'(r_int) * (ACC_W+4)'(RADIX) + (ACC_W+4)'(digit);
    assign cmd_t    = 20'(r_cmd) * 20'(RADIX) + 20'(digit);

    assign o_acc = '{int_accum: r_int, frac_scaled: r_frac, minus: r_minus};

    always_comb begin
        n_mode   = r_mode;
        n_is_m   = r_is_m;
        n_cmd    = r_cmd;
        n_int    = r_int;
        n_frac   = r_frac;
        n_fcnt   = r_fcnt;
        n_minus  = r_minus;
        n_tgt    = r_tgt;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        n_halted = r_halted;
        do_line   = 1'b0;
        do_finish = 1'b0;

        o_step.cnt    = 2'd0;
        o_step.kind0  = KIND_END;
        o_step.kind1  = KIND_END;
        o_step.value0 = '0;

        if (!r_halted) begin
            unique case (r_mode)
                MODE_CMD: begin
                    if (is_digit) begin
                        n_cmd = (cmd_t > 20'(CMD_MAX)) ? CMD_MAX : cmd_t[15:0];
                    end else if (i_byte == CH_MINUS) begin
                        n_cmd = r_cmd;
                    end else if (i_byte == CH_SPACE) begin
                        n_mode = MODE_WORD;
                    end else if (i_byte == CH_DOLLAR) begin
                        o_step.cnt = 2'd1;
                        n_halted   = 1'b1;
                    end else begin
                        n_mode = MODE_LINE;
                    end
                end
                MODE_WORD: begin
                    if (i_byte == CH_S || i_byte == CH_F || i_byte == CH_X ||
                        i_byte == CH_Y || i_byte == CH_Z) begin
                        if (i_byte == CH_S) begin
                            n_tgt = TW_S;
                        end else if (i_byte == CH_F) begin
                            n_tgt = TW_F;
                        end else if (i_byte == CH_X) begin
                            n_tgt = TW_X;
                        end else if (i_byte == CH_Y) begin
                            n_tgt = TW_Y;
                        end else begin
                            n_tgt = TW_Z;
                        end
                        n_int   = '0;
                        n_frac  = '0;
                        n_fcnt  = '0;
                        n_minus = 1'b0;
                        n_mode  = MODE_INT;
                    end else begin
                        do_line = 1'b1;
                    end
                end
                MODE_INT: begin
                    if (is_digit) begin
                        n_int = (int_t > (ACC_W+4)'(VALUE_MAX)) ? VALUE_MAX
                                                                : int_t[ACC_W-1:0];
                    end else if (i_byte == CH_MINUS) begin
                        if (r_tgt != TW_S) begin
                            n_minus = 1'b1;
                        end
                    end else if (i_byte == CH_DOT && r_tgt != TW_S) begin
                        n_mode = MODE_FRAC;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (is_digit) begin
                        // Drop digits beyond the fixed-point precision
                        if (r_fcnt < CNT_W'(FRAC_DIGITS)) begin
                            n_frac = r_frac + FRAC_W'(FRAC_W'(digit) * frac_weight(r_fcnt));
                            n_fcnt = r_fcnt + CNT_W'(1);
                        end
                    end else if (i_byte == CH_MINUS) begin
                        n_minus = 1'b1;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    do_line = 1'b1;
                end
            endcase
        end

        if (do_line) begin
            n_mode = MODE_LINE;
            if (i_byte == CH_DOLLAR) begin
                o_step.cnt = 2'd1;
                n_halted   = 1'b1;
            end else if (i_byte == CH_NL) begin
                n_mode = MODE_LINE;
            end else if (i_byte == CH_G || i_byte == CH_M) begin
                n_is_m = (i_byte == CH_M);
                n_cmd  = '0;
                n_mode = MODE_CMD;
            end else begin
                o_step.cnt   = 2'd1;
                o_step.kind0 = KIND_ERROR;
                n_halted     = 1'b1;
            end
        end

        if (do_finish) begin
            unique case (r_tgt)
                TW_S: begin
                    o_step.cnt    = 2'd1;
                    o_step.kind0  = KIND_SPEED;
                    o_step.value0 = 32'(r_int);
                end
                TW_F: begin
                    o_step.cnt    = 2'd1;
                    o_step.kind0  = KIND_FEED;
                    o_step.value0 = i_real;
                end
                default: begin
                    if (r_tgt == TW_X) begin
                        n_x = i_real;
                    end else if (r_tgt == TW_Y) begin
                        n_y = i_real;
                    end else begin
                        n_z = i_real;
                    end
                    if (r_cmd == 16'd1 || r_cmd == 16'd2) begin
                        o_step.cnt   = 2'd1;
                        o_step.kind0 = r_is_m ? KIND_MCMD : KIND_GCMD;
                    end
                end
            endcase
            if (i_byte == CH_SPACE) begin
                n_mode = MODE_WORD;
            end else if (i_byte == CH_DOLLAR) begin
                // End follows the word's own result, if any
                o_step.cnt = o_step.cnt + 2'd1;
                n_halted   = 1'b1;
            end else begin
                n_mode = MODE_LINE;
            end
        end

        o_step.cmd   = r_cmd;
        o_step.pos_x = n_x;
        o_step.pos_y = n_y;
        o_step.pos_z = n_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LINE;
            r_is_m   <= 1'b0;
            r_cmd    <= '0;
            r_int    <= '0;
            r_frac   <= '0;
            r_fcnt   <= '0;
            r_minus  <= 1'b0;
            r_tgt    <= TW_S;
            r_x      <= '0;
            r_y      <= '0;
            r_z      <= '0;
            r_halted <= 1'b0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_is_m   <= n_is_m;
            r_cmd    <= n_cmd;
            r_int    <= n_int;
            r_frac   <= n_frac;
            r_fcnt   <= n_fcnt;
            r_minus  <= n_minus;
            r_tgt    <= n_tgt;
            r_x      <= n_x;
            r_y      <= n_y;
            r_z      <= n_z;
            r_halted <= n_halted;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gcl_out_q.sv =====
`default_nettype none

module gcl_out_q
    import gcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result    i_e0,
    input  t_result    i_e1,
    output logic [1:0] o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_head
);

    logic [1:0] r_cnt, n_cnt;
    t_result    r_slot [2];
    t_result    n_slot [2];
    logic       pop;
    logic [1:0] keep;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign keep    = r_cnt - 2'(pop);
    assign o_room  = 2'd2 - r_cnt;
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_slot[0];
    assign n_cnt   = keep + i_push_n;

    always_comb begin
        // Head slot: shifted entry, else the first new request
        if (keep != 2'd0) begin
            n_slot[0] = pop ? r_slot[1] : r_slot[0];
        end else if (i_push_n != 2'd0) begin
            n_slot[0] = i_e0;
        end else begin
            n_slot[0] = r_slot[0];
        end

        if (keep == 2'd2) begin
            n_slot[1] = r_slot[1];
        end else if (keep == 2'd1) begin
            n_slot[1] = (i_push_n != 2'd0) ? i_e0 : r_slot[1];
        end else begin
            n_slot[1] = (i_push_n == 2'd2) ? i_e1 : r_slot[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot[0] <= n_slot[0];
        r_slot[1] <= n_slot[1];
    end

endmodule

`default_nettype wire

// ===== hdl/gcode_line_parser.sv =====
`default_nettype none

// Channel   Direction  Handshake                     Payload
// text      in         i_text_valid / o_text_ready   i_text_byte
// result    out        o_res_valid  / i_res_ready    o_kind, o_command_number, o_value,
//                                                    o_pos_x, o_pos_y, o_pos_z, o_last
//
// One byte a cycle while the queue has room: an accepted byte is held in the byte register
// and decoded against the parser state; its zero, one or two result requests enter a
// two-entry queue when it advances. A byte that yields two requests (a word closed by the
// end mark) waits for an empty queue, longer while the consumer stalls.
// The byte register backs up only on queue fill, never on i_res_ready directly.
// Reset (i_rst_n low, synchronous) returns to line start with zero axes, clears halt.

module gcode_line_parser
    import gcl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_text_valid,
    output logic               o_text_ready,
    input  logic [7:0]         i_text_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [2:0]         o_kind,
    output logic [15:0]        o_command_number,
    output logic signed [31:0] o_value,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic               o_last
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               fire;
    logic [1:0]         room;
    t_acc               acc;
    t_step              step;
    logic signed [31:0] real_val;
    t_result            e0;
    t_result            e1;
    t_result            head;

    // Advance the byte register only when its requests all fit in the queue
    assign fire         = r_in_valid && (step.cnt <= room);
    assign o_text_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_text_ready) begin
            r_in_valid <= i_text_valid;
        end
    end

    // Hold the byte until it is decoded
    always_ff @(posedge i_clk) begin
        if (o_text_ready && i_text_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    gcl_fixed u_fixed (
        .i_acc  (acc),
        .o_real (real_val)
    );

    gcl_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_real  (real_val),
        .o_acc   (acc),
        .o_step  (step)
    );

    // First request carries the word's result (or the lone end/error);
    // the second is always the end mark.
    always_comb begin
        e0.kind  = step.kind0;
        e0.cmd   = step.cmd;
        e0.value = step.value0;
        e0.pos_x = step.pos_x;
        e0.pos_y = step.pos_y;
        e0.pos_z = step.pos_z;
        e0.last  = (step.cnt == 2'd1);

        e1.kind  = step.kind1;
        e1.cmd   = step.cmd;
        e1.value = '0;
        e1.pos_x = step.pos_x;
        e1.pos_y = step.pos_y;
        e1.pos_z = step.pos_z;
        e1.last  = 1'b1;
    end

    gcl_out_q u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (fire ? step.cnt : 2'd0),
        .i_e0     (e0),
        .i_e1     (e1),
        .o_room   (room),
        .o_valid  (o_res_valid),
        .i_ready  (i_res_ready),
        .o_head   (head)
    );

    assign o_kind           = head.kind;
    assign o_command_number = head.cmd;
    assign o_value          = head.value;
    assign o_pos_x          = head.pos_x;
    assign o_pos_y          = head.pos_y;
    assign o_pos_z          = head.pos_z;
    assign o_last           = head.last;

endmodule

`default_nettype wire

// ===== test/gcode_parse_checker.sv =====
`timescale 1ns / 100ps

// Watches the text and result channels of the G-code line parser, predicts the
// result requests each accepted text byte causes and compares them in order.
module gcode_parse_checker
    import gcl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_text_valid,
    input  logic               i_text_ready,
    input  logic [7:0]         i_text_byte,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [2:0]         i_kind,
    input  logic [15:0]        i_command_number,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef enum logic [2:0] {AT_LINE, IN_CMD, IN_WORD, IN_INT, IN_FRAC} t_mode;
    typedef enum logic [2:0] {W_SPEED, W_FEED, W_X, W_Y, W_Z} t_word;

    // Command numbers whose axis words raise a G or M event
    localparam int MOVE_CMD_FIRST = 1;
    localparam int MOVE_CMD_LAST  = 2;

    t_mode             mode;
    bit                is_m;
    int                cmd_num;
    longint            whole;
    int                frac_val;
    int                frac_len;
    bit                negative;
    t_word             word_sel;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] z_pos;
    bit                stopped;

    t_result expected_results[$];
    t_result step_res[2];
    int      step_n;

    task automatic queue_result(input t_kind k, input logic [31:0] v);
        if (step_n < 2) begin
            step_res[step_n].kind  = k;
            step_res[step_n].cmd   = 16'(cmd_num);
            step_res[step_n].value = v;
            step_res[step_n].pos_x = x_pos;
            step_res[step_n].pos_y = y_pos;
            step_res[step_n].pos_z = z_pos;
            step_res[step_n].last  = 1'b0;
            step_n++;
        end
    endtask

    task automatic start_line(input logic [7:0] c);
        mode = AT_LINE;
        if (c == CH_DOLLAR) begin
            queue_result(KIND_END, 32'd0);
            stopped = 1'b1;
        end else if (c == CH_G || c == CH_M) begin
            is_m    = (c == CH_M);
            cmd_num = 0;
            mode    = IN_CMD;
        end else if (c != CH_NL) begin
            queue_result(KIND_ERROR, 32'd0);
            stopped = 1'b1;
        end
    endtask

    // Fixed-point magnitude, saturated, then the sign applied to all of it
    function automatic logic [31:0] scaled_value();
        longint mag;
        longint fscale;
        fscale = 1;
        for (int i = frac_len; i < FRAC_DIGITS; i++) begin
            fscale = fscale * RADIX;
        end
        mag = whole * SCALE + longint'(frac_val) * fscale;
        if (mag > longint'(VALUE_MAX)) begin
            mag = longint'(VALUE_MAX);
        end
        return negative ? 32'(-mag) : 32'(mag);
    endfunction

    task automatic close_word(input logic [7:0] c);
        logic [31:0] v;
        if (word_sel == W_SPEED) begin
            queue_result(KIND_SPEED, 32'(whole));
        end else begin
            v = scaled_value();
            if (word_sel == W_FEED) begin
                queue_result(KIND_FEED, v);
            end else begin
                case (word_sel)
                    W_X:     x_pos = v;
                    W_Y:     y_pos = v;
                    default: z_pos = v;
                endcase
                if (cmd_num >= MOVE_CMD_FIRST && cmd_num <= MOVE_CMD_LAST) begin
                    queue_result(is_m ? KIND_MCMD : KIND_GCMD, 32'd0);
                end
            end
        end
        if (c == CH_SPACE) begin
            mode = IN_WORD;
        end else if (c == CH_DOLLAR) begin
            queue_result(KIND_END, 32'd0);
            stopped = 1'b1;
        end else begin
            mode = AT_LINE;
        end
    endtask

    task automatic decode_byte(input logic [7:0] c);
        bit is_digit;
        bit hit;
        int d;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        d        = is_digit ? int'(c - CH_ZERO) : 0;
        hit      = 1'b1;
        step_n   = 0;
        if (!stopped) begin
            case (mode)
                IN_CMD: begin
                    if (is_digit) begin
                        cmd_num = cmd_num * RADIX + d;
                        if (cmd_num > int'(CMD_MAX)) begin
                            cmd_num = int'(CMD_MAX);
                        end
                    end else if (c == CH_SPACE) begin
                        mode = IN_WORD;
                    end else if (c == CH_DOLLAR) begin
                        queue_result(KIND_END, 32'd0);
                        stopped = 1'b1;
                    end else if (c != CH_MINUS) begin
                        mode = AT_LINE;
                    end
                end
                IN_WORD: begin
                    case (c)
                        CH_S:    word_sel = W_SPEED;
                        CH_F:    word_sel = W_FEED;
                        CH_X:    word_sel = W_X;
                        CH_Y:    word_sel = W_Y;
                        CH_Z:    word_sel = W_Z;
                        default: hit = 1'b0;
                    endcase
                    if (hit) begin
                        whole    = 0;
                        frac_val = 0;
                        frac_len = 0;
                        negative = 1'b0;
                        mode     = IN_INT;
                    end else begin
                        start_line(c);
                    end
                end
                IN_INT: begin
                    if (is_digit) begin
                        whole = whole * RADIX + d;
                        if (whole > longint'(VALUE_MAX)) begin
                            whole = longint'(VALUE_MAX);
                        end
                    end else if (c == CH_MINUS) begin
                        if (word_sel != W_SPEED) begin
                            negative = 1'b1;
                        end
                    end else if (c == CH_DOT && word_sel != W_SPEED) begin
                        mode = IN_FRAC;
                    end else begin
                        close_word(c);
                    end
                end
                IN_FRAC: begin
                    if (is_digit) begin
                        // drop digits past the fixed-point resolution
                        if (frac_len < FRAC_DIGITS) begin
                            frac_val = frac_val * RADIX + d;
                            frac_len++;
                        end
                    end else if (c == CH_MINUS) begin
                        negative = 1'b1;
                    end else begin
                        close_word(c);
                    end
                end
                default: start_line(c);
            endcase
        end
        if (step_n > 0) begin
            step_res[step_n - 1].last = 1'b1;
        end
        for (int i = 0; i < step_n; i++) begin
            expected_results.push_back(step_res[i]);
        end
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            mode     = AT_LINE;
            is_m     = 1'b0;
            cmd_num  = 0;
            whole    = 0;
            frac_val = 0;
            frac_len = 0;
            negative = 1'b0;
            word_sel = W_SPEED;
            x_pos    = '0;
            y_pos    = '0;
            z_pos    = '0;
            stopped  = 1'b0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: kind %0d cmd %0d value %0d",
                             $time, i_kind, i_command_number, i_value);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("kind", want.kind, i_kind);
                    compare_field("command_number", want.cmd, i_command_number);
                    compare_field("value", $signed(want.value), i_value);
                    compare_field("pos_x", $signed(want.pos_x), i_pos_x);
                    compare_field("pos_y", $signed(want.pos_y), i_pos_y);
                    compare_field("pos_z", $signed(want.pos_z), i_pos_z);
                    compare_field("last", want.last, i_last);
                end
            end
            if (i_text_valid && i_text_ready) begin
                decode_byte(i_text_byte);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== test/gcode_line_parser_tb.sv =====
`timescale 1ns / 100ps

// Top of the parser bench: clock, reset, text stimulus, result back-pressure,
// a watchdog and the verdict. Prediction and comparison live in the checker.
module gcode_line_parser_tb;
    import gcl_pkg::*;

    localparam int RANDOM_BYTES = 750;
    localparam int HOLD_CYCLES  = 300;   // one long receiver stall
    localparam int HOLD_ROUND   = 40;    // receiver round that starts the stall
    localparam int DRAIN_CYCLES = 20;    // settle time once nothing is expected
    localparam int QUIET_LIMIT  = 5000;  // cycles with no handshake before giving up

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_text_valid = 1'b0;
    logic               o_text_ready;
    logic [7:0]         i_text_byte = 8'd0;
    logic               o_res_valid;
    logic               i_res_ready = 1'b0;
    logic [2:0]         o_kind;
    logic [15:0]        o_command_number;
    logic signed [31:0] o_value;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_pos_z;
    logic               o_last;

    int fail_count;
    int pending_results;
    int quiet_cycles = 0;

    // Text bytes waiting to be offered, in stream order
    logic [7:0] gcode_text[$];
    logic [7:0] word_letters[5] = '{CH_S, CH_F, CH_X, CH_Y, CH_Z};

    // Gap-free stretches on each side, toggled now and then
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    always #1 i_clk = ~i_clk;

    gcode_line_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_valid     (i_text_valid),
        .o_text_ready     (o_text_ready),
        .i_text_byte      (i_text_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_kind           (o_kind),
        .o_command_number (o_command_number),
        .o_value          (o_value),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_pos_z          (o_pos_z),
        .o_last           (o_last)
    );

    gcode_parse_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_valid     (i_text_valid),
        .i_text_ready     (o_text_ready),
        .i_text_byte      (i_text_byte),
        .i_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .i_kind           (o_kind),
        .i_command_number (o_command_number),
        .i_value          (o_value),
        .i_pos_x          (o_pos_x),
        .i_pos_y          (o_pos_y),
        .i_pos_z          (o_pos_z),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending_results)
    );

    // Mostly no gap, some short ones, a few long ones
    function automatic int rand_gap(input bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Digit count: sometimes empty, mostly short, now and then past saturation
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(5, 12);
    endfunction

    // Any byte that closes a number without ending the program; the dot only
    // closes an S word or a fraction
    function automatic logic [7:0] pick_terminator(input bit allow_dot);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_SPACE ||
                   b == CH_DOLLAR || (!allow_dot && b == CH_DOT));
        return b;
    endfunction

    // Append n random digits, with an optional minus dropped at a random spot
    task automatic add_digits(input int n, input bit minus);
        int at;
        at = $urandom_range(0, n);
        for (int i = 0; i <= n; i++) begin
            if (minus && i == at) begin
                gcode_text.push_back(CH_MINUS);
            end
            if (i < n) begin
                gcode_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
        end
    endtask

    // One word: letter, integer part, and for decimals maybe a fraction.
    // dot_ok says whether a dot would close it rather than open a fraction.
    task automatic add_word(input logic [7:0] letter, output bit dot_ok);
        bit frac;
        gcode_text.push_back(letter);
        add_digits(pick_len(), $urandom_range(0, 3) == 0);
        frac = (letter != CH_S) && ($urandom_range(0, 1) == 1);
        if (frac) begin
            gcode_text.push_back(CH_DOT);
            add_digits(pick_len(), $urandom_range(0, 9) == 0);
        end
        dot_ok = (letter == CH_S) || frac;
    endtask

    // One well-formed line with random content; it leaves the parser at line
    // start or waiting for a word, never halted
    task automatic add_line();
        int  words;
        int  r;
        bit  dot_ok;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
            gcode_text.push_back(CH_NL);
        end
        gcode_text.push_back($urandom_range(0, 1) ? CH_M : CH_G);
        // bias toward the move commands so axis events show up often
        r = $urandom_range(0, 9);
        if (r < 6) begin
            gcode_text.push_back(8'(CH_ZERO + $urandom_range(0, 3)));
        end else begin
            add_digits(pick_len(), r == 6);
        end
        r = $urandom_range(0, 19);
        if (r >= 18) begin
            gcode_text.push_back(pick_terminator(1'b1));
        end else if (r >= 15) begin
            gcode_text.push_back(CH_NL);
        end else begin
            gcode_text.push_back(CH_SPACE);
            words = $urandom_range(0, 4);
            for (int i = 0; i < words; i++) begin
                add_word(word_letters[$urandom_range(0, 4)], dot_ok);
                if (i < words - 1) begin
                    gcode_text.push_back(CH_SPACE);
                end
            end
            if (words == 0) begin
                // already waiting for a word: a newline or the next command is fine
                if ($urandom_range(0, 1)) begin
                    gcode_text.push_back(CH_NL);
                end
            end else begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    gcode_text.push_back(CH_NL);
                end else if (r < 9) begin
                    gcode_text.push_back(pick_terminator(dot_ok));
                end else begin
                    gcode_text.push_back(CH_SPACE);
                end
            end
        end
    endtask

    // Offer one byte; hold valid and payload until the parser takes it
    task automatic send_text(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 99) < 3) begin
            tx_steady = !tx_steady;
        end
        gap = rand_gap(tx_steady);
        if (gap > 0) begin
            i_text_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_text_valid <= 1'b1;
        i_text_byte  <= b;
        @(posedge i_clk);
        while (!o_text_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Receiver: random back-pressure, plus one long stall early on so the
    // result queue fills and the text side has to stall
    initial begin
        int gap;
        int rounds;
        rounds = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rounds == HOLD_ROUND) begin
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if ($urandom_range(0, 99) < 3) begin
                    rx_steady = !rx_steady;
                end
                gap = rand_gap(rx_steady);
                if (gap > 0) begin
                    i_res_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_res_ready <= 1'b1;
            @(negedge i_clk);
            rounds++;
        end
    end

    // Watchdog: give up after a long run of cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_text_valid && o_text_ready) || (o_res_valid && i_res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // Directed opener: a blank line, minus inside a command number and an S
        // word, a negative decimal with surplus fraction digits, a feed with no
        // integer part, an M move event, an empty number, and a trailing space
        // before the newline.
        string      directed;
        int         halt_kind;
        bit         dot_ok;
        logic [7:0] b;
        directed = "\nG1-2 X-1.23456 S-7 F.5\nM2 Z \n";
        for (int i = 0; i < directed.len(); i++) begin
            gcode_text.push_back(directed[i]);
        end
        while (gcode_text.size() < directed.len() + RANDOM_BYTES) begin
            add_line();
        end

        // Close the program one of four ways; the run has a single reset, so
        // only one halt is reachable per seed.
        halt_kind = $urandom_range(0, 3);
        case (halt_kind)
            0: gcode_text.push_back(CH_DOLLAR);
            1: begin
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (b == CH_G || b == CH_M || b == CH_NL || b == CH_DOLLAR ||
                           b == CH_S || b == CH_F || b == CH_X || b == CH_Y || b == CH_Z);
                gcode_text.push_back(b);
            end
            2: begin
                // word closed by the end mark: two requests from one byte
                gcode_text.push_back(CH_G);
                gcode_text.push_back(8'(CH_ZERO + 1));
                gcode_text.push_back(CH_SPACE);
                add_word(word_letters[$urandom_range(0, 4)], dot_ok);
                gcode_text.push_back(CH_DOLLAR);
            end
            default: begin
                gcode_text.push_back(CH_M);
                add_digits(pick_len(), 1'b0);
                gcode_text.push_back(CH_DOLLAR);
            end
        endcase
        // After the halt everything must be swallowed without a result
        repeat (16) begin
            gcode_text.push_back(8'($urandom_range(0, 255)));
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        while (gcode_text.size() > 0) begin
            send_text(gcode_text.pop_front());
        end
        i_text_valid <= 1'b0;

        // Drain: wait for every predicted request, then a little longer to
        // catch anything extra
        while (pending_results != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/gcl_pkg.sv
hdl/gcl_fixed.sv
hdl/gcl_parse.sv
hdl/gcl_out_q.sv
hdl/gcode_line_parser.sv
test/gcode_parse_checker.sv
test/gcode_line_parser_tb.sv
